### rtl/core/bgd_pkg.sv
package bgd_pkg;

	// logical inputs per device: stick, button A, button B
	localparam int NUM_INPUTS = 3;

	// front/back queue geometry
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [7:0] TIMER_MAX = 8'hFF;
	localparam logic [3:0] DIR_NONE  = 4'd8;

	// press phase codes
	localparam logic [1:0] PRESS_OFF     = 2'd0;
	localparam logic [1:0] PRESS_PRESS   = 2'd1;
	localparam logic [1:0] PRESS_ON      = 2'd2;
	localparam logic [1:0] PRESS_RELEASE = 2'd3;

	// hold phase codes
	localparam logic [1:0] HOLD_NONE    = 2'd0;
	localparam logic [1:0] HOLD_HOLD    = 2'd1;
	localparam logic [1:0] HOLD_HOLDING = 2'd2;

	typedef struct packed {
		logic       dbl;
		logic [1:0] hold;
		logic [1:0] press;
	} phase_t;

	typedef struct packed {
		phase_t     ph;
		logic [7:0] tm;
	} input_state_t;

	// classified tick handed from front to back
	typedef struct packed {
		logic [1:0] device;
		logic [2:0] on;
		logic [3:0] dir;
	} tick_cls_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	// phase patterns that raise an event
	localparam phase_t PH_CLICK  = '{dbl: 1'b0, hold: HOLD_NONE, press: PRESS_PRESS};
	localparam phase_t PH_REL    = '{dbl: 1'b0, hold: HOLD_NONE, press: PRESS_RELEASE};
	localparam phase_t PH_HOLDEV = '{dbl: 1'b0, hold: HOLD_HOLD, press: PRESS_ON};
	localparam phase_t PH_DCLICK = '{dbl: 1'b1, hold: HOLD_NONE, press: PRESS_PRESS};
	localparam phase_t PH_DHOLD  = '{dbl: 1'b1, hold: HOLD_HOLD, press: PRESS_ON};

	localparam input_state_t STATE_RESET = '{ph: '0, tm: TIMER_MAX};

	// eight-way direction, indexed by active-high {right, left, down, up}
	localparam logic [3:0] DIR_TABLE [16] = '{
		4'd8, 4'd0, 4'd4, 4'd8, 4'd6, 4'd7, 4'd5, 4'd8,
		4'd2, 4'd1, 4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
	};

endpackage

### rtl/core/bgd_if.sv
interface bgd_tick_if;
	logic       valid;
	logic       ready;
	logic [1:0] device;
	logic [7:0] status;

	modport source (output valid, device, status, input ready);
	modport sink (input valid, device, status, output ready);
endinterface

interface bgd_gesture_if;
	logic       valid;
	logic       ready;
	logic [1:0] device_out;
	logic [2:0] click_mask;
	logic [2:0] release_mask;
	logic [2:0] hold_mask;
	logic [2:0] double_click_mask;
	logic [2:0] double_hold_mask;
	logic [3:0] stick_direction;

	modport source (output valid, device_out, click_mask, release_mask, hold_mask,
		double_click_mask, double_hold_mask, stick_direction, input ready);
	modport sink (input valid, device_out, click_mask, release_mask, hold_mask,
		double_click_mask, double_hold_mask, stick_direction, output ready);
endinterface

### rtl/core/bgd_front.sv
module bgd_front
	import bgd_pkg::*;
#(
	parameter int DEVICES = 4
) (
	bgd_tick_if.sink        tick,
	input  q_status_t       q_status,
	output logic            push,
	output tick_cls_t       push_data
);

	localparam logic [4:0] DEV_LIMIT = 5'(DEVICES);

	logic dev_ok;
	logic [3:0] dir_bits;

	// take a beat whenever the queue has room; unknown devices are dropped
	assign tick.ready = !q_status.full;
	assign dev_ok     = {3'b000, tick.device} < DEV_LIMIT;
	assign push       = tick.valid && tick.ready && dev_ok;

	// active-high direction bits
	assign dir_bits = ~tick.status[3:0];

	// classify: which inputs are on, and the stick direction
	always_comb begin
		push_data.device = tick.device;
		push_data.on[0]  = dir_bits != 4'd0;
		push_data.on[1]  = !tick.status[4];
		push_data.on[2]  = !tick.status[5];
		push_data.dir    = DIR_TABLE[dir_bits];
	end

endmodule

### rtl/core/bgd_queue.sv
module bgd_queue
	import bgd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tick_cls_t push_data,
	input  logic      pop,
	output tick_cls_t pop_data,
	output q_status_t status
);

	tick_cls_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.count = count_q;
	assign status.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign pop_data     = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/bgd_back.sv
module bgd_back
	import bgd_pkg::*;
#(
	parameter int DEVICES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] hold_time,
	input  logic [7:0] double_click_time,
	input  tick_cls_t  q_data,
	input  q_status_t  q_status,
	output logic       pop,
	bgd_gesture_if.source gesture
);

	localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

	input_state_t st_q      [DEVICES][NUM_INPUTS];
	logic [2:0]   prev_on_q [DEVICES];

	logic             out_valid_q;
	logic [DEV_W-1:0] idx;
	input_state_t     nxt [NUM_INPUTS];
	logic [2:0]       click, rel, hold, dclick, dhold;

	// one tick of one logical input
	function automatic input_state_t advance(input input_state_t s, input logic cur_on,
		input logic prev_on, input logic [7:0] ht, input logic [7:0] dct);
		phase_t       ph;
		logic [7:0]   tm;
		input_state_t r;
		ph = s.ph;
		tm = (s.tm == TIMER_MAX) ? s.tm : s.tm + 8'd1;
		if (ph.press == PRESS_PRESS) begin
			ph.press = PRESS_ON;
		end else if (ph.press == PRESS_RELEASE) begin
			ph.press = PRESS_OFF;
			ph.hold  = HOLD_NONE;
		end else if (ph.hold == HOLD_NONE && ph.press == PRESS_ON && tm > ht) begin
			ph.hold = HOLD_HOLD;
		end else if (ph.hold == HOLD_HOLD) begin
			ph.hold = HOLD_HOLDING;
		end else if (ph.press == PRESS_OFF && tm > dct) begin
			ph.dbl = 1'b0;
		end
		if (cur_on && !prev_on) begin
			ph.press = PRESS_PRESS;
			if (tm <= dct) begin
				ph.dbl = 1'b1;
			end
			tm = 8'd0;
		end else if (!cur_on && prev_on) begin
			ph = PH_REL;
			tm = 8'd0;
		end
		r.ph = ph;
		r.tm = tm;
		return r;
	endfunction

	// take the next queued tick when the output register frees up
	assign pop           = !q_status.empty && (!out_valid_q || gesture.ready);
	assign gesture.valid = out_valid_q;
	assign idx           = DEV_W'(q_data.device);

	// next state and event masks for the addressed device
	always_comb begin
		for (int k = 0; k < NUM_INPUTS; k++) begin
			nxt[k]    = advance(st_q[idx][k], q_data.on[k], prev_on_q[idx][k],
				hold_time, double_click_time);
			click[k]  = nxt[k].ph == PH_CLICK;
			rel[k]    = nxt[k].ph == PH_REL;
			hold[k]   = nxt[k].ph == PH_HOLDEV;
			dclick[k] = nxt[k].ph == PH_DCLICK;
			dhold[k]  = nxt[k].ph == PH_DHOLD;
		end
	end

	// per-device state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEVICES; i++) begin
				prev_on_q[i] <= 3'b000;
				for (int k = 0; k < NUM_INPUTS; k++) begin
					st_q[i][k] <= STATE_RESET;
				end
			end
		end else if (pop) begin
			for (int i = 0; i < DEVICES; i++) begin
				if (DEV_W'(i) == idx) begin
					prev_on_q[i] <= q_data.on;
					for (int k = 0; k < NUM_INPUTS; k++) begin
						st_q[i][k] <= nxt[k];
					end
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (gesture.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			gesture.device_out        <= q_data.device;
			gesture.click_mask        <= click;
			gesture.release_mask      <= rel;
			gesture.hold_mask         <= hold;
			gesture.double_click_mask <= dclick;
			gesture.double_hold_mask  <= dhold;
			gesture.stick_direction   <= q_data.dir;
		end
	end

endmodule

### rtl/core/button_gesture_detector_core.sv
// A taken tick beat is stored in the queue, then in the output register, where it shows.
// Throughput: one tick per cycle while the sink is ready; each pop updates three inputs.
// A two-entry queue between front and back and a registered output decouple the sides.
// Ticks for a device number at or above DEVICES are taken and give no gesture beat.
// Reset (arst_n low, asynchronous): registers return to 16 and 4, all inputs off,
// timers at 255, previous status nothing pressed, queue and output empty.
module button_gesture_detector_core
	import bgd_pkg::*;
#(
	parameter int DEVICES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	bgd_tick_if.sink    tick,
	bgd_gesture_if.source gesture,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_HOLD_TIME    = 1'b0;
	localparam logic REG_DOUBLE_CLICK = 1'b1;

	logic [7:0] hold_time_q;
	logic [7:0] double_click_time_q;
	logic       reg_sel;
	logic       push;
	logic       pop;
	tick_cls_t  push_data;
	tick_cls_t  pop_data;
	q_status_t  q_status;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q         <= 8'h10;
			double_click_time_q <= 8'h04;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_HOLD_TIME:    hold_time_q         <= pwdata[7:0];
				REG_DOUBLE_CLICK: double_click_time_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HOLD_TIME:    prdata = {24'd0, hold_time_q};
			REG_DOUBLE_CLICK: prdata = {24'd0, double_click_time_q};
		endcase
	end

	bgd_front #(.DEVICES(DEVICES)) u_front (
		.tick      (tick),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	bgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	bgd_back #(.DEVICES(DEVICES)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.hold_time         (hold_time_q),
		.double_click_time (double_click_time_q),
		.q_data            (pop_data),
		.q_status          (q_status),
		.pop               (pop),
		.gesture           (gesture)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> gesture.valid)
		else $error("popped tick did not reach output");

	a_mask_excl: assert property (@(posedge clk) disable iff (!arst_n)
		gesture.valid |-> ((gesture.click_mask & gesture.double_click_mask) == 3'd0 &&
			(gesture.hold_mask & gesture.double_hold_mask) == 3'd0))
		else $error("single and double events on the same input");
`endif

endmodule
